### sv/gzip_header_parser_top_defines.svh
// Assertion helpers for the gzip header parser.
`ifndef GZIP_HEADER_PARSER_TOP_DEFINES_SVH
`define GZIP_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define GZHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication.
`define GZHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GZHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GZHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GZHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define GZHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/gzhp_pkg.sv
`timescale 1ns / 1ps

package gzhp_pkg;

    localparam int PhaseW  = 4;
    localparam int StatusW = 3;
    localparam int SkipW   = 16;
    localparam int FlagsW  = 5;

    typedef logic [PhaseW-1:0]  t_phase;
    typedef logic [StatusW-1:0] t_status;
    typedef logic [SkipW-1:0]   t_skip;
    typedef logic [FlagsW-1:0]  t_flags;

    // parse phases
    localparam t_phase PH_MAGIC0  = 4'd0;
    localparam t_phase PH_MAGIC1  = 4'd1;
    localparam t_phase PH_METHOD  = 4'd2;
    localparam t_phase PH_FLAGS   = 4'd3;
    localparam t_phase PH_FIXED6  = 4'd4;
    localparam t_phase PH_XLEN_LO = 4'd5;
    localparam t_phase PH_XLEN_HI = 4'd6;
    localparam t_phase PH_EXTRA   = 4'd7;
    localparam t_phase PH_NAME    = 4'd8;
    localparam t_phase PH_COMMENT = 4'd9;
    localparam t_phase PH_HCRC    = 4'd10;
    localparam t_phase PH_PAYLOAD = 4'd11;
    localparam t_phase PH_ERR_MAG = 4'd12;
    localparam t_phase PH_ERR_UNS = 4'd13;
    localparam t_phase PH_ERR_TRN = 4'd14;
    localparam t_phase PH_ENDED   = 4'd15;

    // result status codes
    localparam t_status ST_HDR      = 3'd0;
    localparam t_status ST_HDR_END  = 3'd1;
    localparam t_status ST_PAYLOAD  = 3'd2;
    localparam t_status ST_BADMAGIC = 3'd3;
    localparam t_status ST_UNSUP    = 3'd4;
    localparam t_status ST_TRUNC    = 3'd5;
    localparam t_status ST_END      = 3'd6;

    localparam logic [7:0] MAGIC0      = 8'h1F;
    localparam logic [7:0] MAGIC1      = 8'h8B;
    localparam logic [7:0] METHOD_DEFL = 8'h08;
    localparam logic [7:0] FL_RESERVED = 8'hE0;
    localparam int         FL_HCRC     = 1;
    localparam int         FL_EXTRA    = 2;
    localparam int         FL_NAME     = 3;
    localparam int         FL_COMMENT  = 4;

    localparam t_skip FIXED_LEN = 16'd6;
    localparam t_skip HCRC_LEN  = 16'd2;

    // First optional header part at or after 'from' that the flags select;
    // PH_PAYLOAD when none is left.
    function automatic t_phase enter_part(input t_phase from, input t_flags flags);
        t_phase ph;
        ph = PH_PAYLOAD;
        priority if (from <= PH_XLEN_LO && flags[FL_EXTRA]) begin
            ph = PH_XLEN_LO;
        end else if (from <= PH_NAME && flags[FL_NAME]) begin
            ph = PH_NAME;
        end else if (from <= PH_COMMENT && flags[FL_COMMENT]) begin
            ph = PH_COMMENT;
        end else if (from <= PH_HCRC && flags[FL_HCRC]) begin
            ph = PH_HCRC;
        end else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

endpackage

### sv/gzhp_stream_if.sv
`timescale 1ns / 1ps

// Byte channel into the parser.
interface gzhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

// Classified result channel out of the parser.
interface gzhp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [4:0] header_flags;

    modport source (output valid, output status, output payload_byte, output header_flags,
                    input ready);
    modport sink   (input valid, input status, input payload_byte, input header_flags,
                    output ready);
endinterface

### sv/gzhp_parser.sv
`timescale 1ns / 1ps
`include "gzip_header_parser_top_defines.svh"

module gzhp_parser
    import gzhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_of_input,
    output t_status    o_status,
    output logic [7:0] o_payload_byte,
    output t_flags     o_header_flags
);

    t_phase     r_phase,  n_phase;
    t_skip      r_skip,   n_skip;
    t_flags     r_flags,  n_flags;
    logic [7:0] r_method, n_method;

    t_status    w_status;
    logic [7:0] w_payload;
    logic       w_enter;
    t_phase     w_enter_from;
    t_phase     w_next_part;
    t_skip      w_skip_dec;

    assign w_skip_dec  = r_skip - 16'd1;
    assign w_next_part = enter_part(w_enter_from, r_flags);

    always_comb begin
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_flags      = r_flags;
        n_method     = r_method;
        w_status     = ST_HDR;
        w_payload    = 8'h00;
        w_enter      = 1'b0;
        w_enter_from = PH_PAYLOAD;

        unique case (r_phase)
            PH_ERR_MAG: w_status = ST_BADMAGIC;
            PH_ERR_UNS: w_status = ST_UNSUP;
            PH_ERR_TRN: w_status = ST_TRUNC;
            PH_ENDED:   w_status = ST_END;
            PH_PAYLOAD: begin
                if (i_end_of_input) begin
                    n_phase  = PH_ENDED;
                    w_status = ST_END;
                end else begin
                    w_status  = ST_PAYLOAD;
                    w_payload = i_byte_value;
                end
            end
            default: begin
                if (i_end_of_input) begin
                    n_phase  = PH_ERR_TRN;
                    w_status = ST_TRUNC;
                end else begin
                    unique case (r_phase)
                        PH_MAGIC0: begin
                            if (i_byte_value == MAGIC0) begin
                                n_phase = PH_MAGIC1;
                            end else begin
                                n_phase  = PH_ERR_MAG;
                                w_status = ST_BADMAGIC;
                            end
                        end
                        PH_MAGIC1: begin
                            if (i_byte_value == MAGIC1) begin
                                n_phase = PH_METHOD;
                            end else begin
                                n_phase  = PH_ERR_MAG;
                                w_status = ST_BADMAGIC;
                            end
                        end
                        PH_METHOD: begin
                            n_method = i_byte_value;
                            n_phase  = PH_FLAGS;
                        end
                        PH_FLAGS: begin
                            n_flags = i_byte_value[FlagsW-1:0];
                            if (r_method != METHOD_DEFL ||
                                (i_byte_value & FL_RESERVED) != 8'h00) begin
                                n_phase  = PH_ERR_UNS;
                                w_status = ST_UNSUP;
                            end else begin
                                n_phase = PH_FIXED6;
                                n_skip  = FIXED_LEN;
                            end
                        end
                        PH_FIXED6: begin
                            n_skip       = w_skip_dec;
                            w_enter      = (w_skip_dec == '0);
                            w_enter_from = PH_XLEN_LO;
                        end
                        PH_XLEN_LO: begin
                            n_skip  = {8'h00, i_byte_value};
                            n_phase = PH_XLEN_HI;
                        end
                        PH_XLEN_HI: begin
                            n_skip       = r_skip | {i_byte_value, 8'h00};
                            w_enter_from = PH_NAME;
                            if ((r_skip | {i_byte_value, 8'h00}) == '0) begin
                                w_enter = 1'b1;
                            end else begin
                                n_phase = PH_EXTRA;
                            end
                        end
                        PH_EXTRA: begin
                            n_skip       = w_skip_dec;
                            w_enter      = (w_skip_dec == '0);
                            w_enter_from = PH_NAME;
                        end
                        PH_NAME: begin
                            w_enter      = (i_byte_value == 8'h00);
                            w_enter_from = PH_COMMENT;
                        end
                        PH_COMMENT: begin
                            w_enter      = (i_byte_value == 8'h00);
                            w_enter_from = PH_HCRC;
                        end
                        default: begin
                            // header CRC bytes, skipped unchecked
                            n_skip       = w_skip_dec;
                            w_enter      = (w_skip_dec == '0);
                            w_enter_from = PH_PAYLOAD;
                        end
                    endcase

                    if (w_enter) begin
                        n_phase = w_next_part;
                        if (w_next_part == PH_HCRC) begin
                            n_skip = HCRC_LEN;
                        end
                        if (w_next_part == PH_PAYLOAD) begin
                            w_status = ST_HDR_END;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_skip   <= '0;
            r_flags  <= '0;
            r_method <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_flags  <= n_flags;
            r_method <= n_method;
        end
    end

    assign o_status       = w_status;
    assign o_payload_byte = w_payload;
    assign o_header_flags = n_flags;

    `GZHP_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_phase >= PH_ERR_MAG,
        r_phase == $past(r_phase), "terminal phase left before reset")
    `GZHP_ASSERT_NEXT(a_flags_capture, i_clk, i_rst_n,
        i_step && r_phase == PH_FLAGS && !i_end_of_input,
        r_flags == $past(i_byte_value[FlagsW-1:0]), "flag byte not captured")
    `GZHP_ASSERT_IMPL(a_payload_zero, i_clk, i_rst_n, o_status != ST_PAYLOAD,
        o_payload_byte == 8'h00, "payload byte leaks on a header or error result")
    `GZHP_ASSERT_NEXT(a_hdr_end_payload, i_clk, i_rst_n, i_step && o_status == ST_HDR_END,
        r_phase == PH_PAYLOAD, "header end not followed by payload phase")

endmodule

### sv/gzip_header_parser_top.sv
`timescale 1ns / 1ps
// gzip member header parser. Takes one byte per transaction and returns one
// classified result per transaction: header byte, last header byte, payload
// (passed through), or a sticky error / end code. A new byte is accepted every
// cycle while the output is not held off; each result passes through an input
// register and a result register, with the single phase update between them.
// Backpressure on the output stalls the pipeline without loss.

module gzip_header_parser_top
    import gzhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gzhp_in_if.sink     i_in,
    gzhp_out_if.source  o_out
);

    logic       r_in_valid;
    logic [7:0] r_byte_value;
    logic       r_end_of_input;

    logic       r_out_valid;
    t_status    r_status;
    logic [7:0] r_payload_byte;
    t_flags     r_header_flags;

    logic       w_advance;
    logic       w_step;
    t_status    w_status;
    logic [7:0] w_payload_byte;
    t_flags     w_header_flags;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte_value   <= i_in.byte_value;
            r_end_of_input <= i_in.end_of_input;
        end
        if (w_step) begin
            r_status       <= w_status;
            r_payload_byte <= w_payload_byte;
            r_header_flags <= w_header_flags;
        end
    end

    gzhp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_byte_value   (r_byte_value),
        .i_end_of_input (r_end_of_input),
        .o_status       (w_status),
        .o_payload_byte (w_payload_byte),
        .o_header_flags (w_header_flags)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.payload_byte = r_payload_byte;
    assign o_out.header_flags = r_header_flags;

endmodule

### tb/sv/gzhp_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the classification of every accepted byte
// and compares it with the result transactions in order.
module gzhp_result_checker
    import gzhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gzhp_in_if   i_in_mon,
    gzhp_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status    status;
        logic [7:0] payload;
        t_flags     flags;
    } t_gz_result;

    t_phase     cur_phase;
    t_skip      skip_left;
    t_flags     flag_reg;
    logic [7:0] method_reg;
    t_gz_result expected_results[$];
    int         fail_cnt = 0;

    task automatic log_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Move to the first optional header part at or after 'from' that the
    // flags ask for; sets hdr_done when nothing is left but payload.
    task automatic advance_part(input t_phase from, output bit hdr_done);
        hdr_done = 1'b0;
        if (from <= PH_XLEN_LO && flag_reg[FL_EXTRA]) begin
            cur_phase = PH_XLEN_LO;
        end else if (from <= PH_NAME && flag_reg[FL_NAME]) begin
            cur_phase = PH_NAME;
        end else if (from <= PH_COMMENT && flag_reg[FL_COMMENT]) begin
            cur_phase = PH_COMMENT;
        end else if (from <= PH_HCRC && flag_reg[FL_HCRC]) begin
            cur_phase = PH_HCRC;
            skip_left = HCRC_LEN;
        end else begin
            cur_phase = PH_PAYLOAD;
            hdr_done  = 1'b1;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic eoi,
                                 output t_gz_result r);
        bit hdr_done;
        hdr_done = 1'b0;
        r        = '0;
        r.status = ST_HDR;
        case (cur_phase)
            PH_ERR_MAG: r.status = ST_BADMAGIC;
            PH_ERR_UNS: r.status = ST_UNSUP;
            PH_ERR_TRN: r.status = ST_TRUNC;
            PH_ENDED:   r.status = ST_END;
            PH_PAYLOAD: begin
                if (eoi) begin
                    cur_phase = PH_ENDED;
                    r.status  = ST_END;
                end else begin
                    r.status  = ST_PAYLOAD;
                    r.payload = b;
                end
            end
            default: begin
                if (eoi) begin
                    cur_phase = PH_ERR_TRN;
                    r.status  = ST_TRUNC;
                end else begin
                    case (cur_phase)
                        PH_MAGIC0: begin
                            if (b == MAGIC0) begin
                                cur_phase = PH_MAGIC1;
                            end else begin
                                cur_phase = PH_ERR_MAG;
                                r.status  = ST_BADMAGIC;
                            end
                        end
                        PH_MAGIC1: begin
                            if (b == MAGIC1) begin
                                cur_phase = PH_METHOD;
                            end else begin
                                cur_phase = PH_ERR_MAG;
                                r.status  = ST_BADMAGIC;
                            end
                        end
                        PH_METHOD: begin
                            method_reg = b;
                            cur_phase  = PH_FLAGS;
                        end
                        PH_FLAGS: begin
                            flag_reg = b[4:0];
                            if (method_reg != METHOD_DEFL || (b & FL_RESERVED) != 8'h00) begin
                                cur_phase = PH_ERR_UNS;
                                r.status  = ST_UNSUP;
                            end else begin
                                cur_phase = PH_FIXED6;
                                skip_left = FIXED_LEN;
                            end
                        end
                        PH_XLEN_LO: begin
                            skip_left = {8'h00, b};
                            cur_phase = PH_XLEN_HI;
                        end
                        PH_XLEN_HI: begin
                            skip_left = {b, skip_left[7:0]};
                            // empty extra field ends on its second length byte
                            if (skip_left == '0) begin
                                advance_part(PH_NAME, hdr_done);
                            end else begin
                                cur_phase = PH_EXTRA;
                            end
                        end
                        PH_NAME, PH_COMMENT: begin
                            if (b == 8'h00) begin
                                advance_part(t_phase'(cur_phase + 1), hdr_done);
                            end
                        end
                        default: begin
                            // fixed six, extra body and header CRC count down
                            skip_left = skip_left - 1'b1;
                            if (skip_left == '0) begin
                                advance_part(t_phase'(cur_phase + 1), hdr_done);
                            end
                        end
                    endcase
                    if (hdr_done) begin
                        r.status = ST_HDR_END;
                    end
                end
            end
        endcase
        r.flags = flag_reg;
    endtask

    always @(posedge i_clk) begin : check_proc
        t_gz_result exp_r;
        t_gz_result got_r;
        if (!i_rst_n) begin
            cur_phase  = PH_MAGIC0;
            skip_left  = '0;
            flag_reg   = '0;
            method_reg = 8'h00;
            expected_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got_r = {i_out_mon.status, i_out_mon.payload_byte, i_out_mon.header_flags};
                if (expected_results.size() == 0) begin
                    log_failure($sformatf("unexpected result: status %0d payload %02h flags %02h",
                                          got_r.status, got_r.payload, got_r.flags));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        log_failure($sformatf(
                            "mismatch: exp st %0d pay %02h fl %02h, got st %0d pay %02h fl %02h",
                            exp_r.status, exp_r.payload, exp_r.flags,
                            got_r.status, got_r.payload, got_r.flags));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                classify_byte(i_in_mon.byte_value, i_in_mon.end_of_input, exp_r);
                expected_results.push_back(exp_r);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

### tb/sv/gzip_header_parser_top_tb.sv
`timescale 1ns / 1ps

module gzip_header_parser_top_tb;
    import gzhp_pkg::*;

    localparam int TargetItems = 1850;
    localparam int StallLimit  = 5000;
    localparam int HoldCycles  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gzhp_in_if  in_ch ();
    gzhp_out_if out_ch ();

    int         fail_count;
    int         pending_results;
    logic [7:0] stream_byte[$];
    logic       stream_eoi[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_req       = 1'b0;
    int         quiet_cycles   = 0;

    gzip_header_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gzhp_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic push_item(input logic [7:0] b, input logic eoi);
        stream_byte.push_back(b);
        stream_eoi.push_back(eoi);
    endtask

    // no transaction on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("gzip_header_parser_top_tb failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int         total;
        int         scenario;
        int         hdr_len;
        int         cut;
        int         n;
        int         drain_at;
        logic [4:0] hdr_flags;
        logic [7:0] v;
        logic [15:0] xlen;

        in_ch.valid        = 1'b0;
        in_ch.byte_value   = 8'h00;
        in_ch.end_of_input = 1'b0;
        i_rst_n            = 1'b0;

        // one member header; the flags ask for every optional part half the time
        hdr_flags = $urandom_range(0, 1) ? {4'hF, 1'($urandom_range(0, 1))}
                                         : 5'($urandom_range(0, 31));
        push_item(MAGIC0, 1'b0);
        push_item(MAGIC1, 1'b0);
        push_item(METHOD_DEFL, 1'b0);
        push_item({3'b000, hdr_flags}, 1'b0);
        repeat (FIXED_LEN) push_item(8'($urandom_range(0, 255)), 1'b0);
        if (hdr_flags[FL_EXTRA]) begin
            case ($urandom_range(0, 3))
                0:       xlen = 16'd0;
                3:       xlen = 16'd256 + 16'($urandom_range(0, 40));
                default: xlen = 16'($urandom_range(1, 20));
            endcase
            push_item(xlen[7:0], 1'b0);
            push_item(xlen[15:8], 1'b0);
            repeat (xlen) push_item(8'($urandom_range(0, 255)), 1'b0);
        end
        if (hdr_flags[FL_NAME]) begin
            n = $urandom_range(0, 12);
            repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0);
            push_item(8'h00, 1'b0);
        end
        if (hdr_flags[FL_COMMENT]) begin
            n = $urandom_range(0, 12);
            repeat (n) push_item(8'($urandom_range(1, 255)), 1'b0);
            push_item(8'h00, 1'b0);
        end
        if (hdr_flags[FL_HCRC]) begin
            repeat (HCRC_LEN) push_item(8'($urandom_range(0, 255)), 1'b0);
        end
        hdr_len = stream_byte.size();

        // most runs keep the header intact; the rest break it one way
        scenario = $urandom_range(0, 9);
        case (scenario)
            0: begin
                cut = $urandom_range(0, 1);
                v   = 8'($urandom_range(0, 254));
                if (v >= stream_byte[cut]) v++;
                stream_byte[cut] = v;
            end
            1: begin
                if ($urandom_range(0, 1)) begin
                    v = 8'($urandom_range(0, 254));
                    if (v >= METHOD_DEFL) v++;
                    stream_byte[2] = v;
                end else begin
                    stream_byte[3][7:5] = 3'($urandom_range(1, 7));
                end
            end
            2: begin
                // end marker in place of any header byte up to the last, the first one included
                cut = $urandom_range(0, hdr_len - 1);
                while (stream_byte.size() > cut) begin
                    void'(stream_byte.pop_back());
                    void'(stream_eoi.pop_back());
                end
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
            default: ;
        endcase

        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        n = TargetItems - stream_byte.size() - 20;
        repeat (n) push_item(8'($urandom_range(0, 255)), 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
        repeat (19) push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        total    = stream_byte.size();
        drain_at = (total * 3) / 8;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < total; i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            in_ch.valid        <= 1'b1;
            in_ch.byte_value   <= stream_byte[i];
            in_ch.end_of_input <= stream_eoi[i];
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);

            case (((i + 1) * 4) / total)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // long result hold-off while bytes keep coming, so the input backs up
            if (i + 1 == total / 8) hold_req = 1'b1;

            @(negedge i_clk);
            if (i + 1 == drain_at) begin
                in_ch.valid <= 1'b0;
                do @(negedge i_clk); while (pending_results != 0);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_results != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("gzip_header_parser_top_tb passed");
        end else begin
            $display("gzip_header_parser_top_tb failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/gzhp_pkg.sv
sv/gzhp_stream_if.sv
sv/gzhp_parser.sv
sv/gzip_header_parser_top.sv
tb/sv/gzhp_result_checker.sv
tb/sv/gzip_header_parser_top_tb.sv
